// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the list allocator.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
// Next-cycle implication, switched off while reset is held.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`endif

// ===== rtl/ela_pkg.sv =====
// Package of the explicit list allocator: heap geometry, widths, codes.
// No dependencies; used by the core.
package ela_pkg;

  localparam int HEAP_SPAN      = 4096;
  localparam int HEAD_BYTES     = 32;
  localparam int FOOT_BYTES     = 8;
  localparam int OVERHEAD_BYTES = 40;

  localparam int AW = $clog2(HEAP_SPAN);
  localparam int LW = AW + 1;

  typedef logic [AW-1:0] addr_t;
  typedef logic [LW-1:0] link_t;
  typedef logic [12:0]   size_t;
  typedef logic [LW:0]   wide_t;
  typedef logic [7:0]    cnt_t;

  localparam link_t LINK_NONE = link_t'(HEAP_SPAN);
  localparam wide_t HEAP_W    = wide_t'(HEAP_SPAN);
  localparam wide_t HEAD_W    = wide_t'(HEAD_BYTES);
  localparam wide_t FOOT_W    = wide_t'(FOOT_BYTES);
  localparam wide_t OVH_W     = wide_t'(OVERHEAD_BYTES);
  localparam size_t OVH_SZ    = size_t'(OVERHEAD_BYTES);

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_IS_FREE  = 2'd2;
  localparam logic [1:0] ST_TOO_SMALL = 2'd3;

  localparam logic REG_HEAP_SIZE = 1'b0;

  // Byte offset of the footer of a block at b with payload size s.
  function automatic wide_t foot_pos(link_t b, size_t s);
    return wide_t'(b) + wide_t'(s) + HEAD_W;
  endfunction

endpackage

// ===== rtl/ela_if.sv =====
// Request and result channels of the list allocator, valid/ready handshake.
// Uses nothing from ela_pkg; its widths are written out in the ports.
interface ela_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [12:0] request_bytes;
  logic [11:0] payload_address;

  modport source (output valid, req_type, request_bytes, payload_address, input ready);
  modport sink (input valid, req_type, request_bytes, payload_address, output ready);
endinterface

interface ela_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] result_address;
  logic [7:0]  free_blocks;
  logic [12:0] free_total;
  logic [7:0]  used_blocks;
  logic [12:0] used_total;

  modport source (output valid, status, result_address, free_blocks, free_total,
                  used_blocks, used_total, input ready);
  modport sink (input valid, status, result_address, free_blocks, free_total,
                used_blocks, used_total, output ready);
endinterface

// ===== rtl/explicit_list_allocator_core.sv =====
// Explicit free-list heap allocator, first fit, with boundary-tag memories.
// Depends on ela_pkg, the interfaces in ela_if.sv and assert_macros.svh.
//
//   channel  direction  kind          beat
//   in_i     in         valid/ready   one request (allocate, free, init)
//   out_o    out        valid/ready   one result per request
//   apb      in/out     APB, 3b addr  heap_size at byte address 0
//
// Init empties both lists and, if the heap is large enough, makes one available block.
// Allocate walks the available blocks, first fit; free walks the used blocks, one memory read each.
// The single read port of the tag memories sets the walk rate.
// Reset clears the lists and counts at once; the tag memories are not cleared.
// A result waiting on out_o holds the core in its last state until taken.
module explicit_list_allocator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  ela_req_if.sink      in_i,
  ela_res_if.source    out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ela_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INI    = 5'd1;
  localparam logic [4:0] S_AST    = 5'd2;
  localparam logic [4:0] S_AWALK  = 5'd3;
  localparam logic [4:0] S_ADROP  = 5'd4;
  localparam logic [4:0] S_ASPLIT = 5'd5;
  localparam logic [4:0] S_APUSH  = 5'd6;
  localparam logic [4:0] S_APREV  = 5'd7;
  localparam logic [4:0] S_APREV2 = 5'd8;
  localparam logic [4:0] S_FST    = 5'd9;
  localparam logic [4:0] S_FWALK  = 5'd10;
  localparam logic [4:0] S_FDROP  = 5'd11;
  localparam logic [4:0] S_FBELOW = 5'd12;
  localparam logic [4:0] S_FPREV  = 5'd13;
  localparam logic [4:0] S_M0     = 5'd14;
  localparam logic [4:0] S_M1     = 5'd15;
  localparam logic [4:0] S_M2     = 5'd16;
  localparam logic [4:0] S_M3     = 5'd17;
  localparam logic [4:0] S_M4     = 5'd18;
  localparam logic [4:0] S_M5     = 5'd19;
  localparam logic [4:0] S_MEND   = 5'd20;
  localparam logic [4:0] S_DONE   = 5'd21;

  size_t hsize_mem [HEAP_SPAN];
  logic  hused_mem [HEAP_SPAN];
  link_t hnext_mem [HEAP_SPAN];
  link_t hprev_mem [HEAP_SPAN];
  size_t fsize_mem [HEAP_SPAN];

  logic [4:0] state_q, state_d;
  logic [1:0] req_type_q, req_type_d;
  size_t      req_bytes_q, req_bytes_d;
  addr_t      pay_addr_q, pay_addr_d;
  link_t      cur_q, cur_d, blk_q, blk_d, lp_q, lp_d, ln_q, ln_d;
  link_t      tmp_q, tmp_d, below_q, below_d;
  size_t      bsz_q, bsz_d;
  wide_t      hi_q, hi_d;
  cnt_t       walk_cnt_q, walk_cnt_d;
  logic       second_q, second_d;
  logic [1:0] status_q, status_d;
  addr_t      addr_q, addr_d;

  link_t avail_first_q, avail_first_d, used_first_q, used_first_d;
  cnt_t  avail_cnt_q, avail_cnt_d, used_cnt_q, used_cnt_d;
  size_t avail_bytes_q, avail_bytes_d, used_bytes_q, used_bytes_d;
  size_t heap_top_q, heap_top_d, heap_size_q;

  logic       out_valid_q;
  logic [1:0] out_status_q;
  addr_t      out_addr_q;
  cnt_t       out_fcnt_q, out_ucnt_q;
  size_t      out_fbytes_q, out_ubytes_q;
  logic       out_load;

  addr_t rd_addr;
  size_t rd_size_q, rd_foot_q;
  logic  rd_used_q;
  link_t rd_next_q, rd_prev_q;

  logic  hsize_we, hused_we, hnext_we, hprev_we, fsize_we;
  addr_t hsize_wa, hused_wa, hnext_wa, hprev_wa, fsize_wa;
  size_t hsize_wd, fsize_wd;
  logic  hused_wd;
  link_t hnext_wd, hprev_wd;

  logic  alloc_fit;
  link_t split_blk;
  size_t split_sz, heap_lim, merged_sz;
  wide_t foot_w;

  assign alloc_fit = {1'b0, rd_size_q} >= (wide_t'(req_bytes_q) + OVH_W);
  assign split_blk = link_t'(blk_q + req_bytes_q + OVH_SZ);
  assign split_sz  = bsz_q - req_bytes_q - OVH_SZ;
  assign heap_lim  = (heap_size_q > size_t'(HEAP_SPAN)) ? size_t'(HEAP_SPAN) : heap_size_q;
  assign merged_sz = bsz_q + rd_size_q + OVH_SZ;

  assign in_i.ready = (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d       = state_q;
    req_type_d    = req_type_q;
    req_bytes_d   = req_bytes_q;
    pay_addr_d    = pay_addr_q;
    cur_d         = cur_q;
    blk_d         = blk_q;
    lp_d          = lp_q;
    ln_d          = ln_q;
    tmp_d         = tmp_q;
    below_d       = below_q;
    bsz_d         = bsz_q;
    hi_d          = hi_q;
    walk_cnt_d    = walk_cnt_q;
    second_d      = second_q;
    status_d      = status_q;
    addr_d        = addr_q;
    avail_first_d = avail_first_q;
    used_first_d  = used_first_q;
    avail_cnt_d   = avail_cnt_q;
    used_cnt_d    = used_cnt_q;
    avail_bytes_d = avail_bytes_q;
    used_bytes_d  = used_bytes_q;
    heap_top_d    = heap_top_q;
    rd_addr       = '0;
    hsize_we = 1'b0; hsize_wa = '0; hsize_wd = '0;
    hused_we = 1'b0; hused_wa = '0; hused_wd = 1'b0;
    hnext_we = 1'b0; hnext_wa = '0; hnext_wd = '0;
    hprev_we = 1'b0; hprev_wa = '0; hprev_wd = '0;
    fsize_we = 1'b0; fsize_wa = '0; fsize_wd = '0;
    foot_w   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          req_type_d  = in_i.req_type;
          req_bytes_d = in_i.request_bytes;
          pay_addr_d  = in_i.payload_address;
          status_d    = ST_OK;
          addr_d      = '0;
          case (in_i.req_type)
            REQ_ALLOC: state_d = S_AST;
            REQ_FREE:  state_d = S_FST;
            REQ_INIT:  state_d = S_INI;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_INI: begin
        avail_first_d = LINK_NONE;
        used_first_d  = LINK_NONE;
        avail_cnt_d   = '0;
        used_cnt_d    = '0;
        avail_bytes_d = '0;
        used_bytes_d  = '0;
        if (heap_lim < OVH_SZ) begin
          status_d   = ST_TOO_SMALL;
          heap_top_d = '0;
        end else begin
          heap_top_d = heap_lim;
          hsize_we = 1'b1; hsize_wa = '0; hsize_wd = heap_lim - OVH_SZ;
          foot_w   = foot_pos('0, heap_lim - OVH_SZ);
          fsize_we = foot_w < HEAP_W; fsize_wa = foot_w[AW-1:0];
          fsize_wd = heap_lim - OVH_SZ;
          hused_we = 1'b1; hused_wa = '0; hused_wd = 1'b0;
          hprev_we = 1'b1; hprev_wa = '0; hprev_wd = LINK_NONE;
          hnext_we = 1'b1; hnext_wa = '0; hnext_wd = LINK_NONE;
          avail_first_d = '0;
          avail_cnt_d   = cnt_t'(1);
          avail_bytes_d = heap_lim;
        end
        state_d = S_DONE;
      end
      S_AST: begin
        if (avail_cnt_q == '0 || avail_first_q == LINK_NONE) begin
          status_d = ST_NO_FIT;
          state_d  = S_DONE;
        end else begin
          rd_addr    = avail_first_q[AW-1:0];
          cur_d      = avail_first_q;
          walk_cnt_d = avail_cnt_q;
          state_d    = S_AWALK;
        end
      end
      S_AWALK: begin
        if (alloc_fit) begin
          blk_d   = cur_q;
          bsz_d   = rd_size_q;
          lp_d    = rd_prev_q;
          ln_d    = rd_next_q;
          state_d = S_ADROP;
        end else if (walk_cnt_q == cnt_t'(1) || rd_next_q == LINK_NONE) begin
          status_d = ST_NO_FIT;
          state_d  = S_DONE;
        end else begin
          cur_d      = rd_next_q;
          rd_addr    = rd_next_q[AW-1:0];
          walk_cnt_d = walk_cnt_q - cnt_t'(1);
        end
      end
      S_ADROP: begin
        if (lp_q != LINK_NONE) begin
          hnext_we = 1'b1; hnext_wa = lp_q[AW-1:0]; hnext_wd = ln_q;
        end else begin
          avail_first_d = ln_q;
        end
        if (ln_q != LINK_NONE) begin
          hprev_we = 1'b1; hprev_wa = ln_q[AW-1:0]; hprev_wd = lp_q;
        end
        avail_cnt_d   = avail_cnt_q - cnt_t'(1);
        avail_bytes_d = avail_bytes_q - bsz_q - OVH_SZ;
        hsize_we = 1'b1; hsize_wa = blk_q[AW-1:0]; hsize_wd = req_bytes_q;
        foot_w   = foot_pos(blk_q, req_bytes_q);
        fsize_we = foot_w < HEAP_W; fsize_wa = foot_w[AW-1:0]; fsize_wd = req_bytes_q;
        hused_we = 1'b1; hused_wa = blk_q[AW-1:0]; hused_wd = 1'b1;
        state_d  = S_ASPLIT;
      end
      S_ASPLIT: begin
        hsize_we = 1'b1; hsize_wa = split_blk[AW-1:0]; hsize_wd = split_sz;
        foot_w   = foot_pos(split_blk, split_sz);
        fsize_we = foot_w < HEAP_W; fsize_wa = foot_w[AW-1:0]; fsize_wd = split_sz;
        hused_we = 1'b1; hused_wa = split_blk[AW-1:0]; hused_wd = 1'b0;
        hprev_we = 1'b1; hprev_wa = split_blk[AW-1:0]; hprev_wd = LINK_NONE;
        hnext_we = 1'b1; hnext_wa = split_blk[AW-1:0]; hnext_wd = avail_first_q;
        tmp_d         = avail_first_q;
        avail_first_d = split_blk;
        avail_cnt_d   = avail_cnt_q + cnt_t'(1);
        avail_bytes_d = avail_bytes_q + split_sz + OVH_SZ;
        state_d       = S_APUSH;
      end
      S_APUSH: begin
        if (tmp_q != LINK_NONE) begin
          hprev_we = 1'b1; hprev_wa = tmp_q[AW-1:0]; hprev_wd = split_blk;
        end
        hnext_we = 1'b1; hnext_wa = blk_q[AW-1:0]; hnext_wd = used_first_q;
        tmp_d        = used_first_q;
        used_first_d = blk_q;
        used_cnt_d   = used_cnt_q + cnt_t'(1);
        used_bytes_d = used_bytes_q + req_bytes_q + OVH_SZ;
        state_d      = S_APREV;
      end
      S_APREV: begin
        hprev_we = 1'b1; hprev_wa = blk_q[AW-1:0]; hprev_wd = LINK_NONE;
        state_d  = S_APREV2;
      end
      S_APREV2: begin
        if (tmp_q != LINK_NONE) begin
          hprev_we = 1'b1; hprev_wa = tmp_q[AW-1:0]; hprev_wd = blk_q;
        end
        addr_d  = addr_t'(blk_q + link_t'(HEAD_BYTES));
        state_d = S_DONE;
      end
      S_FST: begin
        if ({1'b0, pay_addr_q} < link_t'(HEAD_BYTES) || used_cnt_q == '0 ||
            used_first_q == LINK_NONE) begin
          status_d = ST_IS_FREE;
          state_d  = S_DONE;
        end else begin
          blk_d      = link_t'({1'b0, pay_addr_q} - link_t'(HEAD_BYTES));
          rd_addr    = used_first_q[AW-1:0];
          cur_d      = used_first_q;
          walk_cnt_d = used_cnt_q;
          state_d    = S_FWALK;
        end
      end
      S_FWALK: begin
        if (cur_q == blk_q) begin
          bsz_d   = rd_size_q;
          lp_d    = rd_prev_q;
          ln_d    = rd_next_q;
          state_d = S_FDROP;
        end else if (walk_cnt_q == cnt_t'(1) || rd_next_q == LINK_NONE) begin
          status_d = ST_IS_FREE;
          state_d  = S_DONE;
        end else begin
          cur_d      = rd_next_q;
          rd_addr    = rd_next_q[AW-1:0];
          walk_cnt_d = walk_cnt_q - cnt_t'(1);
        end
      end
      S_FDROP: begin
        if (lp_q != LINK_NONE) begin
          hnext_we = 1'b1; hnext_wa = lp_q[AW-1:0]; hnext_wd = ln_q;
        end else begin
          used_first_d = ln_q;
        end
        if (ln_q != LINK_NONE) begin
          hprev_we = 1'b1; hprev_wa = ln_q[AW-1:0]; hprev_wd = lp_q;
        end
        used_cnt_d   = used_cnt_q - cnt_t'(1);
        used_bytes_d = used_bytes_q - bsz_q - OVH_SZ;
        hused_we = 1'b1; hused_wa = blk_q[AW-1:0]; hused_wd = 1'b0;
        rd_addr  = addr_t'(blk_q - link_t'(FOOT_BYTES));
        state_d  = S_FBELOW;
      end
      S_FBELOW: begin
        if (wide_t'(blk_q) >= FOOT_W &&
            wide_t'(blk_q) - FOOT_W >= HEAD_W + wide_t'(rd_foot_q)) begin
          below_d = link_t'(wide_t'(blk_q) - FOOT_W - HEAD_W - wide_t'(rd_foot_q));
        end else begin
          below_d = LINK_NONE;
        end
        hprev_we = 1'b1; hprev_wa = blk_q[AW-1:0]; hprev_wd = LINK_NONE;
        hnext_we = 1'b1; hnext_wa = blk_q[AW-1:0]; hnext_wd = avail_first_q;
        tmp_d         = avail_first_q;
        avail_first_d = blk_q;
        avail_cnt_d   = avail_cnt_q + cnt_t'(1);
        avail_bytes_d = avail_bytes_q + bsz_q + OVH_SZ;
        state_d       = S_FPREV;
      end
      S_FPREV: begin
        if (tmp_q != LINK_NONE) begin
          hprev_we = 1'b1; hprev_wa = tmp_q[AW-1:0]; hprev_wd = blk_q;
        end
        second_d = 1'b0;
        state_d  = S_M0;
      end
      S_M0: begin
        if (blk_q == LINK_NONE) begin
          state_d = S_DONE;
        end else begin
          rd_addr = blk_q[AW-1:0];
          state_d = S_M1;
        end
      end
      S_M1: begin
        if (rd_used_q) begin
          state_d = S_MEND;
        end else begin
          bsz_d = rd_size_q;
          hi_d  = wide_t'(blk_q) + wide_t'(rd_size_q) + OVH_W;
          if (rd_prev_q != LINK_NONE) begin
            hnext_we = 1'b1; hnext_wa = rd_prev_q[AW-1:0]; hnext_wd = rd_next_q;
          end else begin
            avail_first_d = rd_next_q;
          end
          if (rd_next_q != LINK_NONE) begin
            hprev_we = 1'b1; hprev_wa = rd_next_q[AW-1:0]; hprev_wd = rd_prev_q;
          end
          avail_cnt_d   = avail_cnt_q - cnt_t'(1);
          avail_bytes_d = avail_bytes_q - rd_size_q - OVH_SZ;
          state_d       = S_M2;
        end
      end
      S_M2: begin
        if (hi_q < wide_t'(heap_top_q)) begin
          rd_addr = hi_q[AW-1:0];
          state_d = S_M3;
        end else begin
          state_d = S_M4;
        end
      end
      S_M3: begin
        if (!rd_used_q) begin
          if (rd_prev_q != LINK_NONE) begin
            hnext_we = 1'b1; hnext_wa = rd_prev_q[AW-1:0]; hnext_wd = rd_next_q;
          end else begin
            avail_first_d = rd_next_q;
          end
          if (rd_next_q != LINK_NONE) begin
            hprev_we = 1'b1; hprev_wa = rd_next_q[AW-1:0]; hprev_wd = rd_prev_q;
          end
          avail_cnt_d   = avail_cnt_q - cnt_t'(1);
          avail_bytes_d = avail_bytes_q - rd_size_q - OVH_SZ;
          hsize_we = 1'b1; hsize_wa = blk_q[AW-1:0]; hsize_wd = merged_sz;
          foot_w   = foot_pos(blk_q, merged_sz);
          fsize_we = foot_w < HEAP_W; fsize_wa = foot_w[AW-1:0]; fsize_wd = merged_sz;
          bsz_d    = merged_sz;
        end
        state_d = S_M4;
      end
      S_M4: begin
        hprev_we = 1'b1; hprev_wa = blk_q[AW-1:0]; hprev_wd = LINK_NONE;
        hnext_we = 1'b1; hnext_wa = blk_q[AW-1:0]; hnext_wd = avail_first_q;
        tmp_d         = avail_first_q;
        avail_first_d = blk_q;
        avail_cnt_d   = avail_cnt_q + cnt_t'(1);
        avail_bytes_d = avail_bytes_q + bsz_q + OVH_SZ;
        state_d       = S_M5;
      end
      S_M5: begin
        if (tmp_q != LINK_NONE) begin
          hprev_we = 1'b1; hprev_wa = tmp_q[AW-1:0]; hprev_wd = blk_q;
        end
        state_d = S_MEND;
      end
      S_MEND: begin
        if (!second_q) begin
          second_d = 1'b1;
          blk_d    = below_q;
          state_d  = S_M0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hsize_we) hsize_mem[hsize_wa] <= hsize_wd;
    if (hused_we) hused_mem[hused_wa] <= hused_wd;
    if (hnext_we) hnext_mem[hnext_wa] <= hnext_wd;
    if (hprev_we) hprev_mem[hprev_wa] <= hprev_wd;
    if (fsize_we) fsize_mem[fsize_wa] <= fsize_wd;
    rd_size_q <= hsize_mem[rd_addr];
    rd_used_q <= hused_mem[rd_addr];
    rd_next_q <= hnext_mem[rd_addr];
    rd_prev_q <= hprev_mem[rd_addr];
    rd_foot_q <= fsize_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    req_type_q  <= req_type_d;
    req_bytes_q <= req_bytes_d;
    pay_addr_q  <= pay_addr_d;
    cur_q       <= cur_d;
    blk_q       <= blk_d;
    lp_q        <= lp_d;
    ln_q        <= ln_d;
    tmp_q       <= tmp_d;
    below_q     <= below_d;
    bsz_q       <= bsz_d;
    hi_q        <= hi_d;
    walk_cnt_q  <= walk_cnt_d;
    second_q    <= second_d;
    status_q    <= status_d;
    addr_q      <= addr_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_addr_q   <= addr_q;
      out_fcnt_q   <= avail_cnt_q;
      out_fbytes_q <= avail_bytes_q;
      out_ucnt_q   <= used_cnt_q;
      out_ubytes_q <= used_bytes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      avail_first_q <= LINK_NONE;
      used_first_q  <= LINK_NONE;
      avail_cnt_q   <= '0;
      used_cnt_q    <= '0;
      avail_bytes_q <= '0;
      used_bytes_q  <= '0;
      heap_top_q    <= '0;
      heap_size_q   <= size_t'(HEAP_SPAN);
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      avail_first_q <= avail_first_d;
      used_first_q  <= used_first_d;
      avail_cnt_q   <= avail_cnt_d;
      used_cnt_q    <= used_cnt_d;
      avail_bytes_q <= avail_bytes_d;
      used_bytes_q  <= used_bytes_d;
      heap_top_q    <= heap_top_d;
      if (psel && penable && pwrite && (paddr[2] == REG_HEAP_SIZE)) begin
        heap_size_q <= pwdata[12:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_SIZE) ? {19'b0, heap_size_q} : 32'b0;

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.result_address = out_addr_q;
  assign out_o.free_blocks    = out_fcnt_q;
  assign out_o.free_total     = out_fbytes_q;
  assign out_o.used_blocks    = out_ucnt_q;
  assign out_o.used_total     = out_ubytes_q;

  `include "assert_macros.svh"

  `ASSERT_IMP(a_addr_only_ok, out_valid_q && (out_addr_q != '0), out_status_q == ST_OK)
  `ASSERT_IMP(a_walk_cnt, (state_q == S_AWALK) || (state_q == S_FWALK), walk_cnt_q != '0)
  `ASSERT_IMP(a_empty_avail, (state_q == S_IDLE) && (avail_first_q == LINK_NONE), avail_cnt_q == '0)
  `ASSERT_NXT(a_done_load, out_load, out_valid_q && (state_q == S_IDLE))

endmodule
